@@ design/rrs_pkg.sv @@
`timescale 1ns / 1ps
package rrs_pkg;

    localparam int DEF_MAX_PROCS = 16;
    localparam int ID_W          = 16;
    localparam int TIME_W        = 16;
    localparam int ROUND_W       = 24;
    localparam logic [ROUND_W-1:0] ROUND_MAX = {ROUND_W{1'b1}};

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [ID_W-1:0]   proc_id;
        logic [TIME_W-1:0] required_time;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]    ran_id;
        logic [ROUND_W-1:0] round_number;
        logic [TIME_W-1:0]  used_time;
        logic               finished;
        logic               all_done;
    } t_out_item;

    typedef enum logic {
        OP_LOAD,
        OP_TICK
    } t_op_kind;

    // decoded item as it waits in the queue between front and back
    typedef struct packed {
        t_op_kind          kind;
        logic              need_zero;
        logic [ID_W-1:0]   proc_id;
        logic [TIME_W-1:0] need;
    } t_op;

    // one row of the process table
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] need;
        logic [TIME_W-1:0] used;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic {
        BE_IDLE,
        BE_UPDATE
    } t_be_state;

endpackage

@@ design/rrs_ram.sv @@
`timescale 1ns / 1ps
module rrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/rrs_front.sv @@
`timescale 1ns / 1ps
module rrs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rrs_pkg::t_in_item i_in_item,
    output logic              o_op_valid,
    output rrs_pkg::t_op      o_op,
    input  logic              i_op_pop
);
    import rrs_pkg::*;

    t_op        r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       accept;
    logic       pop;
    t_op        n_op;

    assign o_in_stall = (r_cnt == 2'd2);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_op_valid = (r_cnt != 2'd0);
    assign pop        = i_op_pop && o_op_valid;
    assign o_op       = r_q[r_rd_ptr];

    always_comb begin
        n_op.kind      = (i_in_item.cmd == CMD_TICK) ? OP_TICK : OP_LOAD;
        n_op.need_zero = (i_in_item.required_time == '0);
        n_op.proc_id   = i_in_item.proc_id;
        n_op.need      = i_in_item.required_time;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (accept) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({accept, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> (r_cnt == 2'd2))
        else $error("queue lost an item while full");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd3))
        else $error("queue count beyond depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

@@ design/rrs_back.sv @@
`timescale 1ns / 1ps
module rrs_back #(
    parameter int MAX_PROCS = rrs_pkg::DEF_MAX_PROCS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_op_valid,
    input  rrs_pkg::t_op       i_op,
    output logic               o_op_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rrs_pkg::t_out_item o_out_item
);
    import rrs_pkg::*;

    localparam int SLOT_W = $clog2(MAX_PROCS);
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PROCS);

    t_be_state            r_state, n_state;
    logic [MAX_PROCS-1:0] r_active, n_active;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [SLOT_W-1:0]    r_last, n_last;
    logic [ROUND_W-1:0]   r_tick, n_tick;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    logic                 out_free;
    logic                 tick_go;
    logic [MAX_PROCS-1:0] higher;
    logic [MAX_PROCS-1:0] cand;
    logic [MAX_PROCS-1:0] low1;
    logic [MAX_PROCS-1:0] cnt_mask;
    logic [SLOT_W-1:0]    pick_idx;
    logic                 any_active;

    logic                 ram_wr_en;
    logic [SLOT_W-1:0]    ram_wr_addr;
    t_entry               ram_wr_data;
    logic                 ram_rd_en;
    t_entry               ram_rd_data;
    logic [TIME_W-1:0]    used_inc;
    logic                 upd_fin;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign any_active = |r_active;

    // rotating pick: first active slot above the last one that ran, else lowest active
    always_comb begin
        for (int i = 0; i < MAX_PROCS; i++) begin
            higher[i]   = r_active[i] && (r_last < SLOT_W'(i));
            cnt_mask[i] = (CNT_W'(i) < r_count);
        end
        cand     = (|higher) ? higher : r_active;
        low1     = cand & (~cand + MAX_PROCS'(1));
        pick_idx = '0;
        for (int i = 0; i < MAX_PROCS; i++) begin
            if (low1[i]) begin
                pick_idx = pick_idx | SLOT_W'(i);
            end
        end
    end

    assign tick_go  = i_op_valid && (i_op.kind == OP_TICK) && out_free && any_active;
    assign used_inc = ram_rd_data.used + TIME_W'(1);
    assign upd_fin  = (used_inc >= ram_rd_data.need);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BE_IDLE:   if (tick_go) n_state = BE_UPDATE;
            BE_UPDATE: n_state = BE_IDLE;
            default:   n_state = BE_IDLE;
        endcase
    end

    always_comb begin
        o_op_pop    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_slot;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        n_active    = r_active;
        n_count     = r_count;
        n_last      = r_last;
        n_tick      = r_tick;
        n_slot      = r_slot;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        unique case (r_state)
            BE_IDLE: begin
                if (i_op_valid && i_op.kind == OP_LOAD) begin
                    o_op_pop = 1'b1;
                    // table full drops the load
                    if (r_count != CNT_FULL) begin
                        ram_wr_en        = 1'b1;
                        ram_wr_addr      = r_count[SLOT_W-1:0];
                        ram_wr_data.id   = i_op.proc_id;
                        ram_wr_data.need = i_op.need;
                        ram_wr_data.used = '0;
                        n_active[r_count[SLOT_W-1:0]] = !i_op.need_zero;
                        n_count  = r_count + CNT_W'(1);
                    end
                end else if (i_op_valid && i_op.kind == OP_TICK && out_free) begin
                    o_op_pop = 1'b1;
                    if (any_active) begin
                        ram_rd_en = 1'b1;
                        n_slot    = pick_idx;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out       = '0;
                        n_out.all_done = 1'b1;
                    end
                end
            end
            BE_UPDATE: begin
                ram_wr_en        = 1'b1;
                ram_wr_addr      = r_slot;
                ram_wr_data.used = used_inc;
                if (upd_fin) begin
                    n_active[r_slot] = 1'b0;
                end
                if (r_tick != ROUND_MAX) begin
                    n_tick = r_tick + ROUND_W'(1);
                end
                n_last             = r_slot;
                n_out_valid        = 1'b1;
                n_out.ran_id       = ram_rd_data.id;
                n_out.round_number = n_tick;
                n_out.used_time    = used_inc;
                n_out.finished     = upd_fin;
                n_out.all_done     = 1'b0;
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    rrs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PROCS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (pick_idx),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BE_IDLE;
            r_active    <= '0;
            r_count     <= '0;
            r_last      <= SLOT_W'(MAX_PROCS - 1);
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_count     <= n_count;
            r_last      <= n_last;
            r_tick      <= n_tick;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BE_UPDATE) |=> (r_state == BE_IDLE))
        else $error("update held longer than one cycle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BE_UPDATE) |-> !r_out_valid)
        else $error("update would overwrite a pending result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_active & ~cnt_mask) == '0))
        else $error("active slot beyond the loaded entries");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BE_UPDATE && upd_fin) |=> !r_active[r_slot])
        else $error("finished entry still in the ring");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.all_done) |-> (r_out.round_number != '0))
        else $error("round number zero on a ran tick");

endmodule

@@ design/round_robin_time_slice_scheduler_unit.sv @@
`timescale 1ns / 1ps
// Round-robin scheduler with a one-tick time slice over a table of MAX_PROCS
// process entries. A load item (cmd 0) appends an entry and gives no result; a
// tick item (cmd 1) runs the next active entry after the one that ran last and
// gives one result, or a result with all_done set when nothing is left. Items
// enter a two-deep queue, so the input can still take items while a result
// waits on the output register. In the execution unit a load or an all_done
// tick is done in the idle state; a tick that runs an entry does the rotating
// pick and table read in idle, then the increment and write-back of that
// entry's used time in update, as the table memory registers its read data.
// A tick starts only once the output register is free.
module round_robin_time_slice_scheduler_unit #(
    parameter int MAX_PROCS = rrs_pkg::DEF_MAX_PROCS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rrs_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rrs_pkg::t_out_item o_out_item
);
    import rrs_pkg::*;

    logic op_valid;
    t_op  op;
    logic op_pop;

    rrs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_op_valid (op_valid),
        .o_op       (op),
        .i_op_pop   (op_pop)
    );

    rrs_back #(
        .MAX_PROCS (MAX_PROCS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (op_valid),
        .i_op        (op),
        .o_op_pop    (op_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

@@ verif/tb_round_robin_time_slice_scheduler_unit.sv @@
`timescale 1ns / 1ps
module tb_round_robin_time_slice_scheduler_unit;
    import rrs_pkg::*;

    localparam int SLOTS        = DEF_MAX_PROCS;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 20;

    typedef enum int {
        ST_FREE,
        ST_COIN,
        ST_HEAVY,
        ST_TOGGLE
    } t_stall_mode;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    // mirror of the process table
    logic [ID_W-1:0]    slot_id   [SLOTS];
    logic [TIME_W-1:0]  slot_need [SLOTS];
    logic [TIME_W-1:0]  slot_used [SLOTS];
    logic [SLOTS-1:0]   slot_live   = '0;
    int                 slots_taken = 0;
    int                 prev_slot   = SLOTS - 1;
    logic [ROUND_W-1:0] rounds_run  = '0;

    t_out_item pending_reports[$];
    int        err_cnt    = 0;
    int        cycle_cnt  = 0;
    int        burst_left = 0;

    round_robin_time_slice_scheduler_unit #(
        .MAX_PROCS(SLOTS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void add_proc(input logic [ID_W-1:0] pid,
                                     input logic [TIME_W-1:0] need);
        if (slots_taken >= SLOTS) begin
            return;
        end
        slot_id[slots_taken]   = pid;
        slot_need[slots_taken] = need;
        slot_used[slots_taken] = '0;
        slot_live[slots_taken] = (need != '0);
        slots_taken++;
    endfunction

    function automatic t_out_item run_tick();
        t_out_item r;
        int        slot;
        int        c;
        bit        hit;
        r    = '0;
        slot = 0;
        hit  = 1'b0;
        for (int k = 1; k <= SLOTS; k++) begin
            c = (prev_slot + k) % SLOTS;
            if (!hit && c < slots_taken && slot_live[c]) begin
                slot = c;
                hit  = 1'b1;
            end
        end
        if (!hit) begin
            r.all_done = 1'b1;
            return r;
        end
        slot_used[slot] = slot_used[slot] + 1'b1;
        if (rounds_run != ROUND_MAX) begin
            rounds_run++;
        end
        prev_slot = slot;
        if (slot_used[slot] >= slot_need[slot]) begin
            slot_live[slot] = 1'b0;
        end
        r.ran_id       = slot_id[slot];
        r.round_number = rounds_run;
        r.used_time    = slot_used[slot];
        r.finished     = !slot_live[slot];
        r.all_done     = 1'b0;
        return r;
    endfunction

    function automatic t_in_item make_load(input logic [ID_W-1:0] pid,
                                           input logic [TIME_W-1:0] need);
        t_in_item it;
        it.cmd           = CMD_LOAD;
        it.proc_id       = pid;
        it.required_time = need;
        return it;
    endfunction

    // id and time fields of a tick are don't-care, so fill them with noise
    function automatic t_in_item make_tick();
        t_in_item it;
        it.cmd           = CMD_TICK;
        it.proc_id       = ID_W'($urandom);
        it.required_time = TIME_W'($urandom);
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    task automatic send_item(input t_in_item it);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        if (it.cmd == CMD_TICK) begin
            pending_reports.push_back(run_tick());
        end else begin
            add_proc(it.proc_id, it.required_time);
        end
    endtask

    task automatic send_paced(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        send_item(it);
    endtask

    task automatic drain_reports();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic test_empty_tick();
        send_paced(make_tick());
        send_paced(make_tick());
    endtask

    task automatic test_zero_need();
        // zero-time entry takes a slot but never runs
        send_paced(make_load(16'h0000, 16'h0000));
        send_paced(make_tick());
        send_paced(make_tick());
    endtask

    task automatic test_ring_order();
        send_paced(make_load(16'hFFFF, 16'd1));
        send_paced(make_load(16'h1234, 16'd3));
        send_paced(make_tick());
        send_paced(make_tick());
        // joins the ring while another entry is still running
        send_paced(make_load(16'hA5A5, 16'd2));
        repeat (5) send_paced(make_tick());
    endtask

    task automatic test_random_mix(input int n);
        int                done_cnt;
        int                pick;
        logic [TIME_W-1:0] need;
        bit                do_load;
        done_cnt = 0;
        while (done_cnt < n) begin
            if (slot_live == '0) begin
                do_load = ($urandom_range(0, 5) == 0);
            end else begin
                do_load = ($urandom_range(0, 89) == 0);
            end
            if (slots_taken < SLOTS && do_load) begin
                pick = $urandom_range(0, 19);
                if (pick < 2) begin
                    need = '0;
                end else if (pick < 5) begin
                    need = TIME_W'($urandom_range(1, 4));
                end else begin
                    need = TIME_W'($urandom_range(30, 250));
                end
                send_paced(make_load(ID_W'($urandom), need));
                done_cnt++;
            end else if (slots_taken == SLOTS && $urandom_range(0, 39) == 0) begin
                // dropped load, noise only
                send_paced(make_load(ID_W'($urandom), TIME_W'($urandom)));
            end else begin
                send_paced(make_tick());
                done_cnt++;
            end
        end
    endtask

    task automatic test_table_full();
        while (slots_taken < SLOTS) begin
            send_paced(make_load(ID_W'($urandom), TIME_W'($urandom_range(0, 3))));
        end
        send_paced(make_load(16'hFFFF, 16'hFFFF));
        send_paced(make_load(16'h0000, 16'h0000));
        send_paced(make_load(16'h5A5A, 16'd1));
        while (slot_live != '0) begin
            send_paced(make_tick());
        end
        send_paced(make_tick());
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (out_valid && !out_stall) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("result with none pending", 64'(out_item), 64'(0));
            end else begin
                want = pending_reports.pop_front();
                if (out_item.ran_id !== want.ran_id) begin
                    report_mismatch("ran_id", 64'(out_item.ran_id), 64'(want.ran_id));
                end
                if (out_item.round_number !== want.round_number) begin
                    report_mismatch("round_number", 64'(out_item.round_number),
                                    64'(want.round_number));
                end
                if (out_item.used_time !== want.used_time) begin
                    report_mismatch("used_time", 64'(out_item.used_time),
                                    64'(want.used_time));
                end
                if (out_item.finished !== want.finished) begin
                    report_mismatch("finished", 64'(out_item.finished),
                                    64'(want.finished));
                end
                if (out_item.all_done !== want.all_done) begin
                    report_mismatch("all_done", 64'(out_item.all_done),
                                    64'(want.all_done));
                end
            end
        end
    end

    initial begin
        t_stall_mode mode;
        int          span;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(8, 60);
            repeat (span) begin
                @(posedge clk);
                case (mode)
                    ST_FREE: begin
                        out_stall <= 1'b0;
                    end
                    ST_COIN: begin
                        out_stall <= ($urandom_range(0, 1) == 1);
                    end
                    ST_HEAVY: begin
                        out_stall <= ($urandom_range(0, 4) != 0);
                    end
                    default: begin
                        out_stall <= ~out_stall;
                    end
                endcase
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("round_robin_time_slice_scheduler_unit verification failed");
        $finish;
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_tick();
        drain_reports();
        test_zero_need();
        drain_reports();
        test_ring_order();
        drain_reports();
        test_random_mix(RANDOM_ITEMS);
        drain_reports();
        test_table_full();
        drain_reports();
        repeat (SETTLE) @(posedge clk);
        if (err_cnt == 0 && pending_reports.size() == 0) begin
            $display("round_robin_time_slice_scheduler_unit verification clean");
        end else begin
            $display("round_robin_time_slice_scheduler_unit verification failed");
        end
        $finish;
    end

endmodule

@@ round_robin_time_slice_scheduler_unit.f @@
design/rrs_pkg.sv
design/rrs_ram.sv
design/rrs_front.sv
design/rrs_back.sv
design/round_robin_time_slice_scheduler_unit.sv
verif/tb_round_robin_time_slice_scheduler_unit.sv
